>>> rtl/pae_pkg.sv
`default_nettype none
package pae_pkg;

    // Register map of the configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINKS      = 1'd1;

    // Register widths and reset values
    localparam int CFG_NODES_W = 11;
    localparam int CFG_LINKS_W = 4;
    localparam logic [CFG_NODES_W-1:0] NODES_RST = 11'd1024;
    localparam logic [CFG_LINKS_W-1:0] LINKS_RST = 4'd2;

    // Item field widths
    localparam int DRAW_W     = 14;
    localparam int NODE_OUT_W = 10;

    // Item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DRAW  = 1'b1;

    // Default sizes
    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_LINKS = 8;

    // Controller to datapath commands
    typedef struct packed {
        logic start;    // latch run sizes, rewind the store
        logic seed;     // one seed write
        logic rd;       // store read at the draw index
        logic check;    // duplicate check and slot fill
        logic emit_a;   // target write, edge to output register
        logic emit_b;   // new-node write, advance
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_start;     // input item is a start
        logic draw_ok;      // draw is in range and the run is active
        logic seed_last;    // current seed write is the final one
        logic no_edges;     // links not below node count
        logic dup;          // read endpoint already a target
        logic slots_full;   // next slot fill completes the targets
        logic emit_last;    // current edge is the last of the node
        logic out_free;     // output register can take an edge
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/pae_ram.sv
`default_nettype none
module pae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/pae_ctrl.sv
`default_nettype none
module pae_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  pae_pkg::t_sts     i_sts,
    output pae_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEED   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_EMIT_A = 3'd3;
    localparam logic [2:0] S_EMIT_B = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // input is taken only between items
    assign o_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_sts.is_start) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SEED;
                    end else if (i_sts.draw_ok) begin
                        o_cmd.rd = 1'b1;
                        n_state  = S_CHECK;
                    end
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                if (i_sts.seed_last) begin
                    n_state = i_sts.no_edges ? S_IDLE : S_EMIT_A;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = (!i_sts.dup && i_sts.slots_full) ? S_EMIT_A : S_IDLE;
            end
            S_EMIT_A: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_a = 1'b1;
                    n_state      = S_EMIT_B;
                end
            end
            S_EMIT_B: begin
                o_cmd.emit_b = 1'b1;
                n_state = i_sts.emit_last ? S_IDLE : S_EMIT_A;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> rtl/pae_dp.sv
`default_nettype none
module pae_dp #(
    parameter int MAX_NODES = pae_pkg::DEF_MAX_NODES,
    parameter int MAX_LINKS = pae_pkg::DEF_MAX_LINKS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration writes
    input  wire                                i_cfg_we,
    input  wire [pae_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [pae_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input fields
    input  wire                                i_kind,
    input  wire [pae_pkg::DRAW_W-1:0]          i_draw_index,
    // controller link
    input  pae_pkg::t_cmd                      i_cmd,
    output pae_pkg::t_sts                      o_sts,
    // result channel
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [pae_pkg::NODE_OUT_W-1:0]     o_edge_old_node,
    output logic [pae_pkg::NODE_OUT_W-1:0]     o_edge_new_node,
    output logic                               o_last_of_node,
    output logic                               o_graph_done
);

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int RUNN_W  = $clog2(MAX_NODES + 1);
    localparam int LINK_W  = $clog2(MAX_LINKS + 1);
    localparam int SLOT_W  = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int DEPTH   = 2 * MAX_LINKS * MAX_NODES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int IDXC_W  = (pae_pkg::DRAW_W > FILL_W) ? pae_pkg::DRAW_W : FILL_W;
    localparam int NCMP_W  = (pae_pkg::CFG_NODES_W > RUNN_W) ? pae_pkg::CFG_NODES_W : RUNN_W;
    localparam int MCMP_W  = (pae_pkg::CFG_LINKS_W > LINK_W) ? pae_pkg::CFG_LINKS_W : LINK_W;
    localparam int MN_W    = (LINK_W > RUNN_W) ? LINK_W : RUNN_W;
    localparam int SN_W    = (LINK_W > NODE_W) ? LINK_W : NODE_W;
    localparam int ONODE_W = (pae_pkg::NODE_OUT_W > RUNN_W) ? pae_pkg::NODE_OUT_W : RUNN_W;

    localparam logic [RUNN_W-1:0] NODES_RST_RUN = RUNN_W'(MAX_NODES);
    localparam logic [LINK_W-1:0] LINKS_RST_RUN =
        LINK_W'((MAX_LINKS < 2) ? MAX_LINKS : 2);

    // configuration and run sizes
    logic [pae_pkg::CFG_NODES_W-1:0] r_cfg_nodes;
    logic [pae_pkg::CFG_LINKS_W-1:0] r_cfg_links;
    logic [RUNN_W-1:0]               r_run_n;
    logic [LINK_W-1:0]               r_run_m;

    // run state
    logic [FILL_W-1:0]  r_fill;
    logic [RUNN_W-1:0]  r_next;
    logic [LINK_W-1:0]  r_tfill;
    logic               r_finished;
    logic [LINK_W-1:0]  r_seed_node;
    logic [LINK_W:0]    r_seed_j;
    logic [LINK_W-1:0]  r_emit_j;
    logic [NODE_W-1:0]  r_slot [MAX_LINKS];

    // output register
    logic                           r_out_valid;
    logic [pae_pkg::NODE_OUT_W-1:0] r_out_old;
    logic [pae_pkg::NODE_OUT_W-1:0] r_out_new;
    logic                           r_out_last;
    logic                           r_out_done;

    logic [NCMP_W-1:0] w_n_ext;
    logic [NCMP_W-1:0] w_n_clamp;
    logic [MCMP_W-1:0] w_m_ext;
    logic [MCMP_W-1:0] w_m_clamp;
    logic [MN_W-1:0]   w_run_m_mn;
    logic [MN_W-1:0]   w_run_n_mn;
    logic [IDXC_W-1:0] w_idx_ext;
    logic [IDXC_W-1:0] w_fill_ext;
    logic [SN_W-1:0]   w_seed_ext;
    logic [ONODE_W-1:0] w_old_ext;
    logic [ONODE_W-1:0] w_new_ext;
    logic [NODE_W-1:0] w_slot_j;
    logic [NODE_W-1:0] w_rdata;
    logic [NODE_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_addr;
    logic              w_we;
    logic              w_dup;
    logic              w_seed_row_end;
    logic              w_node_end;

    // clamp the registers into the supported run sizes
    assign w_n_ext = NCMP_W'(r_cfg_nodes);
    assign w_m_ext = MCMP_W'(r_cfg_links);
    always_comb begin
        if (w_n_ext < NCMP_W'(2)) begin
            w_n_clamp = NCMP_W'(2);
        end else if (w_n_ext > NCMP_W'(MAX_NODES)) begin
            w_n_clamp = NCMP_W'(MAX_NODES);
        end else begin
            w_n_clamp = w_n_ext;
        end
        if (w_m_ext < MCMP_W'(1)) begin
            w_m_clamp = MCMP_W'(1);
        end else if (w_m_ext > MCMP_W'(MAX_LINKS)) begin
            w_m_clamp = MCMP_W'(MAX_LINKS);
        end else begin
            w_m_clamp = w_m_ext;
        end
    end

    assign w_run_m_mn = MN_W'(r_run_m);
    assign w_run_n_mn = MN_W'(r_run_n);

    // draw range check against the store fill
    assign w_idx_ext  = IDXC_W'(i_draw_index);
    assign w_fill_ext = IDXC_W'(r_fill);

    // duplicate compare across the held targets
    always_comb begin
        w_dup = 1'b0;
        for (int k = 0; k < MAX_LINKS; k++) begin
            if ((LINK_W'(k) < r_tfill) && (r_slot[k] == w_rdata)) begin
                w_dup = 1'b1;
            end
        end
    end

    assign w_seed_row_end = ((r_seed_j + (LINK_W + 1)'(1)) == {r_run_m, 1'b0});
    assign w_node_end     = (({1'b0, r_next} + (RUNN_W + 1)'(1)) >= {1'b0, r_run_n});
    assign w_slot_j       = r_slot[r_emit_j[SLOT_W-1:0]];

    // status to the controller
    always_comb begin
        o_sts            = '0;
        o_sts.is_start   = (i_kind == pae_pkg::KIND_START);
        o_sts.draw_ok    = !r_finished && (w_idx_ext < w_fill_ext);
        o_sts.seed_last  = w_seed_row_end
                           && ((r_seed_node + LINK_W'(1)) == r_run_m);
        o_sts.no_edges   = (w_run_m_mn >= w_run_n_mn);
        o_sts.dup        = w_dup;
        o_sts.slots_full = ((r_tfill + LINK_W'(1)) == r_run_m);
        o_sts.emit_last  = ((r_emit_j + LINK_W'(1)) == r_run_m);
        o_sts.out_free   = !r_out_valid || !i_stall;
    end

    // endpoint store port: reads at the draw index, writes append at the fill
    assign w_seed_ext = SN_W'(r_seed_node);
    assign w_we       = i_cmd.seed || i_cmd.emit_a || i_cmd.emit_b;
    assign w_addr     = i_cmd.rd ? w_idx_ext[ADDR_W-1:0] : r_fill[ADDR_W-1:0];
    always_comb begin
        if (i_cmd.seed) begin
            w_wdata = w_seed_ext[NODE_W-1:0];
        end else if (i_cmd.emit_a) begin
            w_wdata = w_slot_j;
        end else begin
            w_wdata = r_next[NODE_W-1:0];
        end
    end

    pae_ram #(
        .WIDTH (NODE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (i_cmd.rd),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_nodes <= pae_pkg::NODES_RST;
            r_cfg_links <= pae_pkg::LINKS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == pae_pkg::REG_NODE_COUNT) begin
                r_cfg_nodes <= i_cfg_data;
            end else if (i_cfg_index == pae_pkg::REG_LINKS) begin
                r_cfg_links <= i_cfg_data[pae_pkg::CFG_LINKS_W-1:0];
            end
        end
    end

    // run control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_n     <= NODES_RST_RUN;
            r_run_m     <= LINKS_RST_RUN;
            r_fill      <= '0;
            r_next      <= '0;
            r_tfill     <= '0;
            r_finished  <= 1'b1;
            r_seed_node <= '0;
            r_seed_j    <= '0;
            r_emit_j    <= '0;
        end else begin
            if (i_cmd.start) begin
                r_run_n     <= w_n_clamp[RUNN_W-1:0];
                r_run_m     <= w_m_clamp[LINK_W-1:0];
                r_fill      <= '0;
                r_seed_node <= '0;
                r_seed_j    <= '0;
                r_emit_j    <= '0;
            end
            if (i_cmd.seed) begin
                r_fill <= r_fill + FILL_W'(1);
                if (w_seed_row_end) begin
                    r_seed_j    <= '0;
                    r_seed_node <= r_seed_node + LINK_W'(1);
                end else begin
                    r_seed_j <= r_seed_j + (LINK_W + 1)'(1);
                end
                if (o_sts.seed_last) begin
                    r_next     <= w_run_m_mn[RUNN_W-1:0];
                    r_finished <= o_sts.no_edges;
                    r_tfill    <= o_sts.no_edges ? '0 : r_run_m;
                    r_emit_j   <= '0;
                end
            end
            if (i_cmd.check && !w_dup) begin
                r_tfill <= r_tfill + LINK_W'(1);
            end
            if (i_cmd.emit_a) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (i_cmd.emit_b) begin
                r_fill <= r_fill + FILL_W'(1);
                if (o_sts.emit_last) begin
                    r_emit_j   <= '0;
                    r_tfill    <= '0;
                    r_next     <= r_next + RUNN_W'(1);
                    r_finished <= w_node_end;
                end else begin
                    r_emit_j <= r_emit_j + LINK_W'(1);
                end
            end
        end
    end

    // target slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed && o_sts.seed_last) begin
            for (int k = 0; k < MAX_LINKS; k++) begin
                r_slot[k] <= NODE_W'(k);
            end
        end else if (i_cmd.check && !w_dup) begin
            r_slot[r_tfill[SLOT_W-1:0]] <= w_rdata;
        end
    end

    // output register
    assign w_old_ext = ONODE_W'(w_slot_j);
    assign w_new_ext = ONODE_W'(r_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_a) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_a) begin
            r_out_old  <= w_old_ext[pae_pkg::NODE_OUT_W-1:0];
            r_out_new  <= w_new_ext[pae_pkg::NODE_OUT_W-1:0];
            r_out_last <= o_sts.emit_last;
            r_out_done <= o_sts.emit_last && w_node_end;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_edge_old_node = r_out_old;
    assign o_edge_new_node = r_out_new;
    assign o_last_of_node  = r_out_last;
    assign o_graph_done    = r_out_done;

endmodule
`default_nettype wire

>>> rtl/preferential_attachment_edge_gen_top.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_kind, i_draw_index
// result    out        o_valid / i_stall    o_edge_old_node, o_edge_new_node,
//                                           o_last_of_node, o_graph_done
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A draw is handled as the transfer, then the endpoint store read and the
// duplicate compare against the target slots.
// A draw that completes the targets goes on to emit links_per_node edges,
// each with one store write for the target and one for the new node on the
// single store port; the result side can stall each edge.
// A start takes 2*m*m seed writes (m = clamped links_per_node) followed,
// when m is below the clamped node count, by the edges of the first new node.
// Reset clears the control state only; the store needs no clearing pass.
`default_nettype none
module preferential_attachment_edge_gen_top #(
    parameter int MAX_NODES = pae_pkg::DEF_MAX_NODES,
    parameter int MAX_LINKS = pae_pkg::DEF_MAX_LINKS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // input channel
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire                              i_kind,
    input  wire [pae_pkg::DRAW_W-1:0]        i_draw_index,
    // result channel
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [pae_pkg::NODE_OUT_W-1:0]   o_edge_old_node,
    output logic [pae_pkg::NODE_OUT_W-1:0]   o_edge_new_node,
    output logic                             o_last_of_node,
    output logic                             o_graph_done,
    // configuration channel
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [pae_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [pae_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    pae_pkg::t_cmd w_cmd;
    pae_pkg::t_sts w_sts;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    pae_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    pae_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_LINKS (MAX_LINKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_draw_index    (i_draw_index),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_edge_old_node (o_edge_old_node),
        .o_edge_new_node (o_edge_new_node),
        .o_last_of_node  (o_last_of_node),
        .o_graph_done    (o_graph_done)
    );

endmodule
`default_nettype wire

>>> rtl/pae_chk.sv
`default_nettype none
module pae_chk (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_valid,
    input wire                             o_stall,
    input wire                             i_kind,
    input wire                             o_valid,
    input wire                             i_stall,
    input wire [pae_pkg::NODE_OUT_W-1:0]   o_edge_old_node,
    input wire [pae_pkg::NODE_OUT_W-1:0]   o_edge_new_node,
    input wire                             o_last_of_node,
    input wire                             o_graph_done
);

    // the graph ends only on the last edge of a node
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_of_node || !o_graph_done))
        else $error("graph_done without last_of_node");

    // more edges of the node still to come: no new input transfer
    a_busy_mid_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_node) |-> o_stall)
        else $error("input taken in the middle of a node's edges");

    // a start always goes on to seed the store
    a_start_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_kind == pae_pkg::KIND_START)) |=> o_stall)
        else $error("start transfer not followed by seeding");

    // a stalled edge holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_edge_old_node)
            && $stable(o_edge_new_node)))
        else $error("stalled edge changed");

endmodule

bind preferential_attachment_edge_gen_top pae_chk u_pae_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_kind          (i_kind),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_edge_old_node (o_edge_old_node),
    .o_edge_new_node (o_edge_new_node),
    .o_last_of_node  (o_last_of_node),
    .o_graph_done    (o_graph_done)
);
`default_nettype wire

>>> bench/preferential_attachment_edge_gen_top_tb.sv
`timescale 1ns / 100ps
module preferential_attachment_edge_gen_top_tb;

    localparam int STORE_DEPTH = 2 * pae_pkg::DEF_MAX_LINKS * pae_pkg::DEF_MAX_NODES;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 150;   // covers a full seed pass with no edges

    typedef struct packed {
        logic                         kind;
        logic [pae_pkg::DRAW_W-1:0]   idx;
    } t_attach_req;

    typedef struct packed {
        logic [pae_pkg::NODE_OUT_W-1:0] old_node;
        logic [pae_pkg::NODE_OUT_W-1:0] new_node;
        logic                           last;
        logic                           done;
    } t_attach_edge;

    // Clock, reset and DUT signals
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic                            in_kind = pae_pkg::KIND_START;
    logic [pae_pkg::DRAW_W-1:0]      in_draw = '0;
    logic                            res_valid;
    logic                            res_stall = 1'b0;
    logic [pae_pkg::NODE_OUT_W-1:0]  res_old;
    logic [pae_pkg::NODE_OUT_W-1:0]  res_new;
    logic                            res_last;
    logic                            res_done;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pae_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [pae_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Stimulus bookkeeping
    t_attach_req    queued_items[$];
    t_attach_edge   expected_edges[$];
    t_attach_req    drive_item;
    bit             in_taken = 1'b0;
    int             n_pushed = 0;
    int             n_accepted = 0;
    int             n_errors = 0;
    int             cycle_count = 0;
    int             idle_pct = 0;
    int             stall_pct = 0;

    // Predictor state
    logic [pae_pkg::NODE_OUT_W-1:0]  model_endpoints [STORE_DEPTH];
    logic [pae_pkg::NODE_OUT_W-1:0]  model_targets [pae_pkg::DEF_MAX_LINKS];
    int unsigned                     model_fill = 0;
    int unsigned                     model_next = 0;
    int unsigned                     model_tfill = 0;
    bit                              model_over = 1'b1;
    int unsigned                     run_nodes = pae_pkg::DEF_MAX_NODES;
    int unsigned                     run_links = 2;
    logic [pae_pkg::CFG_NODES_W-1:0] cfg_nodes = pae_pkg::NODES_RST;
    logic [pae_pkg::CFG_LINKS_W-1:0] cfg_links = pae_pkg::LINKS_RST;

    preferential_attachment_edge_gen_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_stall         (in_stall),
        .i_kind          (in_kind),
        .i_draw_index    (in_draw),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_edge_old_node (res_old),
        .o_edge_new_node (res_new),
        .o_last_of_node  (res_last),
        .o_graph_done    (res_done),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // Append one (target,new) pair per target and queue the edges
    function automatic void append_node_edges();
        int unsigned  node;
        t_attach_edge e;
        node = model_next;
        if (model_fill + 2 * run_links > STORE_DEPTH || model_tfill < run_links) begin
            model_over = 1'b1;
            return;
        end
        for (int j = 0; j < run_links; j++) begin
            model_endpoints[model_fill + 2 * j]     = model_targets[j];
            model_endpoints[model_fill + 2 * j + 1] = node[pae_pkg::NODE_OUT_W-1:0];
            e.old_node = model_targets[j];
            e.new_node = node[pae_pkg::NODE_OUT_W-1:0];
            e.last     = (j + 1 == run_links);
            e.done     = (j + 1 == run_links) && (node + 1 >= run_nodes);
            expected_edges.push_back(e);
        end
        model_fill  += 2 * run_links;
        model_next  = node + 1;
        model_tfill = 0;
        if (model_next >= run_nodes)
            model_over = 1'b1;
    endfunction

    // Expected behavior of one accepted item
    function automatic void predict_attach(input logic kind,
                                           input logic [pae_pkg::DRAW_W-1:0] idx);
        int unsigned n;
        int unsigned m;
        logic [pae_pkg::NODE_OUT_W-1:0] v;
        if (kind == pae_pkg::KIND_START) begin
            n = cfg_nodes;
            m = cfg_links;
            if (n < 2) n = 2;
            if (n > pae_pkg::DEF_MAX_NODES) n = pae_pkg::DEF_MAX_NODES;
            if (m < 1) m = 1;
            if (m > pae_pkg::DEF_MAX_LINKS) m = pae_pkg::DEF_MAX_LINKS;
            run_nodes = n;
            run_links = m;
            for (int i = 0; i < m; i++)
                for (int j = 0; j < 2 * m; j++)
                    model_endpoints[i * 2 * m + j] = i[pae_pkg::NODE_OUT_W-1:0];
            model_fill = 2 * m * m;
            for (int i = 0; i < m; i++)
                model_targets[i] = i[pae_pkg::NODE_OUT_W-1:0];
            model_tfill = m;
            model_next  = m;
            model_over  = 1'b0;
            if (m >= n) begin
                model_tfill = 0;
                model_over  = 1'b1;
            end else begin
                append_node_edges();
            end
            return;
        end
        // ignored draws: no run, or past the filled part
        if (model_over || idx >= model_fill)
            return;
        v = model_endpoints[idx];
        for (int i = 0; i < model_tfill && i < pae_pkg::DEF_MAX_LINKS; i++)
            if (model_targets[i] == v)
                return;
        if (model_tfill >= run_links || model_tfill >= pae_pkg::DEF_MAX_LINKS) begin
            append_node_edges();
            return;
        end
        model_targets[model_tfill] = v;
        model_tfill++;
        if (model_tfill >= run_links)
            append_node_edges();
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
        n_errors++;
    endtask

    task automatic check_edge();
        t_attach_edge want;
        if (expected_edges.size() == 0) begin
            report_mismatch("edge with none pending, old node", res_old, -1);
            return;
        end
        want = expected_edges.pop_front();
        if (res_old !== want.old_node)
            report_mismatch("edge_old_node", res_old, want.old_node);
        if (res_new !== want.new_node)
            report_mismatch("edge_new_node", res_new, want.new_node);
        if (res_last !== want.last)
            report_mismatch("last_of_node", res_last, want.last);
        if (res_done !== want.done)
            report_mismatch("graph_done", res_done, want.done);
    endtask

    // Monitor: transfers on both channels, cycle limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("preferential_attachment_edge_gen_top_tb NOT OK");
            $finish;
        end else if (rst_n) begin
            if (in_valid && !in_stall) begin
                predict_attach(in_kind, in_draw);
                n_accepted++;
                in_taken = 1'b1;
            end
            if (res_valid && !res_stall)
                check_edge();
        end
    end

    // Driver: input items from the queue, random result stalls
    always @(negedge clk) begin
        res_stall <= ($urandom_range(0, 99) < stall_pct);
        if (!in_valid || in_taken) begin
            in_taken = 1'b0;
            if (queued_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                drive_item = queued_items.pop_front();
                in_kind  <= drive_item.kind;
                in_draw  <= drive_item.idx;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic push_item(input logic kind, input logic [pae_pkg::DRAW_W-1:0] idx);
        t_attach_req r;
        r.kind = kind;
        r.idx  = idx;
        queued_items.push_back(r);
        n_pushed++;
    endtask

    // Push one item and wait for its transfer so the model state is current
    task automatic send_and_wait(input logic kind, input logic [pae_pkg::DRAW_W-1:0] idx);
        push_item(kind, idx);
        while (n_accepted != n_pushed) @(negedge clk);
    endtask

    task automatic wait_quiet();
        while (n_accepted != n_pushed || expected_edges.size() != 0) @(negedge clk);
    endtask

    // Idle before a register write: an item without edges may still be busy
    task automatic settle();
        wait_quiet();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [pae_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pae_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == pae_pkg::REG_NODE_COUNT)
            cfg_nodes = data;
        else
            cfg_links = data[pae_pkg::CFG_LINKS_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int in_pct, input int out_pct);
        idle_pct  = in_pct;
        stall_pct = out_pct;
    endtask

    // Mostly in-range draws; restarts now and then, noise draws at the fill or anywhere in the index range
    task automatic run_phase(input int count, input int noise_pct);
        send_and_wait(pae_pkg::KIND_START, $urandom_range(0, 16383));
        repeat (count - 1) begin
            while (queued_items.size() >= 2) @(negedge clk);
            if ((model_over && $urandom_range(0, 3) != 0) || $urandom_range(0, 39) == 0)
                send_and_wait(pae_pkg::KIND_START, $urandom_range(0, 16383));
            else if (model_over || model_fill == 0 || $urandom_range(0, 99) < noise_pct)
                push_item(pae_pkg::KIND_DRAW, $urandom_range(0, 1) ? model_fill
                                                                   : $urandom_range(0, 16383));
            else
                push_item(pae_pkg::KIND_DRAW, $urandom_range(0, model_fill - 1));
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part with the reset sizes: 1024 nodes, 2 links
        set_idling(0, 0);
        send_and_wait(pae_pkg::KIND_DRAW, '0);            // draw before any start
        send_and_wait(pae_pkg::KIND_DRAW, '1);
        send_and_wait(pae_pkg::KIND_START, 14'h2AAA);
        send_and_wait(pae_pkg::KIND_DRAW, model_fill);    // first index past the fill
        send_and_wait(pae_pkg::KIND_DRAW, '1);
        send_and_wait(pae_pkg::KIND_DRAW, 0);
        send_and_wait(pae_pkg::KIND_DRAW, 1);             // same endpoint again
        send_and_wait(pae_pkg::KIND_DRAW, model_fill - 1);
        send_and_wait(pae_pkg::KIND_DRAW, 0);
        send_and_wait(pae_pkg::KIND_DRAW, 4);
        send_and_wait(pae_pkg::KIND_START, 14'h1555);     // restart mid-run
        repeat (8) send_and_wait(pae_pkg::KIND_DRAW, $urandom_range(0, model_fill - 1));
        settle();

        // Small graph, whole runs complete
        write_reg(pae_pkg::REG_NODE_COUNT, 11'd5);
        write_reg(pae_pkg::REG_LINKS, 11'h7F3);
        run_phase(15, 10);
        settle();

        // Both registers zero: clamps to two nodes, one link, then draws after done
        write_reg(pae_pkg::REG_NODE_COUNT, 11'd0);
        write_reg(pae_pkg::REG_LINKS, 11'd0);
        set_idling(67, 0);
        run_phase(4, 10);
        settle();

        // Node count above the maximum, one link per node
        write_reg(pae_pkg::REG_NODE_COUNT, 11'h7FF);
        write_reg(pae_pkg::REG_LINKS, 11'd1);
        set_idling(0, 67);
        run_phase(15, 10);
        settle();

        // Links not below node count: seeded, no edges
        write_reg(pae_pkg::REG_NODE_COUNT, 11'd8);
        write_reg(pae_pkg::REG_LINKS, 11'd8);
        set_idling(15, 15);
        run_phase(3, 10);
        settle();
        write_reg(pae_pkg::REG_NODE_COUNT, 11'd3);
        write_reg(pae_pkg::REG_LINKS, 11'd15);
        run_phase(2, 10);
        settle();

        // Widest fan-in
        write_reg(pae_pkg::REG_NODE_COUNT, 11'd10);
        write_reg(pae_pkg::REG_LINKS, 11'd8);
        run_phase(30, 5);
        settle();

        // Sender holds off once until everything has drained
        write_reg(pae_pkg::REG_NODE_COUNT, 11'd9);
        write_reg(pae_pkg::REG_LINKS, 11'd4);
        set_idling(0, 0);
        run_phase(10, 10);
        wait_quiet();
        run_phase(10, 10);
        settle();

        write_reg(pae_pkg::REG_NODE_COUNT, 11'd6);
        write_reg(pae_pkg::REG_LINKS, 11'd2);
        set_idling(67, 0);
        run_phase(7, 10);

        wait_quiet();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (n_errors == 0)
            $display("preferential_attachment_edge_gen_top_tb OK");
        else
            $display("preferential_attachment_edge_gen_top_tb NOT OK");
        $finish;
    end

endmodule

>>> preferential_attachment_edge_gen_top.f
rtl/pae_pkg.sv
rtl/pae_ram.sv
rtl/pae_ctrl.sv
rtl/pae_dp.sv
rtl/preferential_attachment_edge_gen_top.sv
rtl/pae_chk.sv
bench/preferential_attachment_edge_gen_top_tb.sv
